>>> rtl/core/dual_encoder_speed_meter_ema_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual encoder speed meter
// Immediate-consequence and next-cycle implication checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef DUAL_ENCODER_SPEED_METER_EMA_TOP_MACROS_SVH
`define DUAL_ENCODER_SPEED_METER_EMA_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define DESM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("desm: same-cycle check failed");
`define DESM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("desm: next-cycle check failed");
`else
`define DESM_ASSERT_IMP(lbl, ante, cons)
`define DESM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/desm_pkg.sv
// ----------------------------------------------------------------------------
// desm_pkg
// Shared widths, codes, lane interface types and saturation helpers.
// ----------------------------------------------------------------------------
package desm_pkg;

    localparam int NUM_LANES  = 2;
    localparam int CNT_W      = 32;
    localparam int WIN_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int CIRC_W     = 20;
    localparam int CIRC100_W  = 27;
    localparam int NUM_W      = 58;
    localparam int DEN_W      = 18;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
    localparam int DIFF_W     = CNT_W + 1;
    localparam int PROD_W     = DIFF_W + GAIN_W + 1;
    localparam int EMA_SUM_W  = 36;
    localparam int Q_SHIFT    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int RPM_SCALE  = 100000;
    localparam int RPM_DEN    = 11;
    localparam int SPD_SCALE  = 100;
    localparam int SPD_DEN    = 660;

    localparam logic [WIN_W-1:0]  WINDOW_RST = 8'd5;
    localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd8192;
    localparam logic [CIRC_W-1:0] CIRC_RST   = 20'd204204;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_TICKS = 2'd0,
        CFG_EMA_GAIN     = 2'd1,
        CFG_WHEEL_CIRC   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                     start;
        logic                     release_res;
        logic                     clear;
        logic                     first;
        logic signed [CNT_W-1:0]  sum;
        logic [WIN_W-1:0]         win;
        logic [GAIN_W-1:0]        gain;
        logic [CIRC_W-1:0]        circ;
    } lane_cmd_t;

    typedef struct packed {
        logic                     done;
        logic signed [CNT_W-1:0]  raw_rpm;
        logic signed [CNT_W-1:0]  raw_spd;
        logic signed [CNT_W-1:0]  filt_rpm;
        logic signed [CNT_W-1:0]  filt_spd;
    } lane_sts_t;

    // sign and magnitude quotient to saturated 32-bit value
    function automatic logic signed [CNT_W-1:0] sat_quot(input logic neg,
                                                         input logic [NUM_W-1:0] mag);
        logic signed [CNT_W-1:0] r;
        if (!neg) begin
            if (mag[NUM_W-1:CNT_W-1] != '0) begin
                r = {1'b0, {(CNT_W-1){1'b1}}};
            end
            else begin
                r = signed'(mag[CNT_W-1:0]);
            end
        end
        else begin
            if (mag[NUM_W-1:CNT_W-1] != '0) begin
                r = {1'b1, {(CNT_W-1){1'b0}}};
            end
            else begin
                r = -signed'(mag[CNT_W-1:0]);
            end
        end
        return r;
    endfunction

    function automatic logic signed [CNT_W-1:0] sat_ema(
            input logic signed [EMA_SUM_W-1:0] v);
        logic signed [CNT_W-1:0] r;
        if (v[EMA_SUM_W-1:CNT_W-1] == {(EMA_SUM_W-CNT_W+1){v[EMA_SUM_W-1]}}) begin
            r = v[CNT_W-1:0];
        end
        else if (v[EMA_SUM_W-1]) begin
            r = {1'b1, {(CNT_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(CNT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> rtl/core/desm_div.sv
// ----------------------------------------------------------------------------
// desm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module desm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [desm_pkg::NUM_W-1:0]     num,
    input  logic [desm_pkg::DEN_W-1:0]     den,
    output logic                           done,
    output logic [desm_pkg::NUM_W-1:0]     quo
);

    logic [desm_pkg::NUM_W-1:0]     quo_reg;
    logic [desm_pkg::DEN_W-1:0]     rem_reg;
    logic [desm_pkg::DEN_W-1:0]     den_reg;
    logic [desm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [desm_pkg::DEN_W:0]       rem_sh;
    logic [desm_pkg::DEN_W:0]       diff;
    logic                           ge;
    logic [desm_pkg::DEN_W-1:0]     rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[desm_pkg::NUM_W-1]};
        diff     = rem_sh - {1'b0, den_reg};
        ge       = (rem_sh >= {1'b0, den_reg});
        rem_next = ge ? diff[desm_pkg::DEN_W-1:0] : rem_sh[desm_pkg::DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= desm_pkg::DIV_CNT_W'(desm_pkg::NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == desm_pkg::DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[desm_pkg::NUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> rtl/core/desm_lane.sv
// ----------------------------------------------------------------------------
// desm_lane
// One motor: window sum to raw rpm and speed, then Q15 EMA update.
// ----------------------------------------------------------------------------
`include "dual_encoder_speed_meter_ema_top_macros.svh"

module desm_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  desm_pkg::lane_cmd_t   cmd,
    output desm_pkg::lane_sts_t   sts
);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_DSTART,
        L_DIV,
        L_EMA_MUL,
        L_EMA_ADD,
        L_DONE
    } state_t;

    state_t                                  state_reg;
    logic                                    neg_reg;
    logic                                    first_reg;
    logic [desm_pkg::CNT_W-1:0]              mag_reg;
    logic [desm_pkg::CIRC100_W-1:0]          circ100_reg;
    logic [desm_pkg::GAIN_W-1:0]             gain_reg;
    logic [desm_pkg::DEN_W-1:0]              den_rpm_reg;
    logic [desm_pkg::DEN_W-1:0]              den_spd_reg;
    logic [desm_pkg::NUM_W-1:0]              num_rpm_reg;
    logic [desm_pkg::NUM_W-1:0]              num_spd_reg;
    logic signed [desm_pkg::CNT_W-1:0]       raw_rpm_reg;
    logic signed [desm_pkg::CNT_W-1:0]       raw_spd_reg;
    logic signed [desm_pkg::PROD_W-1:0]      prod_rpm_reg;
    logic signed [desm_pkg::PROD_W-1:0]      prod_spd_reg;
    logic signed [desm_pkg::CNT_W-1:0]       filt_rpm_reg;
    logic signed [desm_pkg::CNT_W-1:0]       filt_spd_reg;

    logic [desm_pkg::WIN_W-1:0]              win_eff;
    logic signed [desm_pkg::DIFF_W-1:0]      d_rpm;
    logic signed [desm_pkg::DIFF_W-1:0]      d_spd;
    logic signed [desm_pkg::GAIN_W:0]        gain_s;
    logic                                    div_start;
    logic                                    rpm_done;
    logic                                    spd_done;
    logic [desm_pkg::NUM_W-1:0]              rpm_quo;
    logic [desm_pkg::NUM_W-1:0]              spd_quo;

    always_comb
    begin
        win_eff   = (cmd.win == '0) ? desm_pkg::WIN_W'(1) : cmd.win;
        d_rpm     = {raw_rpm_reg[desm_pkg::CNT_W-1], raw_rpm_reg}
                  - {filt_rpm_reg[desm_pkg::CNT_W-1], filt_rpm_reg};
        d_spd     = {raw_spd_reg[desm_pkg::CNT_W-1], raw_spd_reg}
                  - {filt_spd_reg[desm_pkg::CNT_W-1], filt_spd_reg};
        gain_s    = signed'({1'b0, gain_reg});
        div_start = (state_reg == L_DSTART);
    end

    desm_div u_div_rpm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_rpm_reg),
        .den   (den_rpm_reg),
        .done  (rpm_done),
        .quo   (rpm_quo)
    );

    desm_div u_div_spd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_spd_reg),
        .den   (den_spd_reg),
        .done  (spd_done),
        .quo   (spd_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= L_IDLE;
            neg_reg      <= 1'b0;
            first_reg    <= 1'b1;
            mag_reg      <= '0;
            circ100_reg  <= '0;
            gain_reg     <= '0;
            den_rpm_reg  <= '0;
            den_spd_reg  <= '0;
            num_rpm_reg  <= '0;
            num_spd_reg  <= '0;
            raw_rpm_reg  <= '0;
            raw_spd_reg  <= '0;
            prod_rpm_reg <= '0;
            prod_spd_reg <= '0;
            filt_rpm_reg <= '0;
            filt_spd_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE:
                begin
                    if (cmd.clear)
                    begin
                        filt_rpm_reg <= '0;
                        filt_spd_reg <= '0;
                    end
                    if (cmd.start)
                    begin
                        neg_reg     <= cmd.sum[desm_pkg::CNT_W-1];
                        mag_reg     <= cmd.sum[desm_pkg::CNT_W-1] ? unsigned'(-cmd.sum)
                                                                  : unsigned'(cmd.sum);
                        first_reg   <= cmd.first;
                        gain_reg    <= cmd.gain;
                        circ100_reg <= desm_pkg::CIRC100_W'(cmd.circ)
                                     * desm_pkg::CIRC100_W'(desm_pkg::SPD_SCALE);
                        den_rpm_reg <= desm_pkg::DEN_W'(win_eff)
                                     * desm_pkg::DEN_W'(desm_pkg::RPM_DEN);
                        den_spd_reg <= desm_pkg::DEN_W'(win_eff)
                                     * desm_pkg::DEN_W'(desm_pkg::SPD_DEN);
                        state_reg   <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    num_rpm_reg <= desm_pkg::NUM_W'(mag_reg)
                                 * desm_pkg::NUM_W'(desm_pkg::RPM_SCALE);
                    num_spd_reg <= desm_pkg::NUM_W'(mag_reg)
                                 * desm_pkg::NUM_W'(circ100_reg);
                    state_reg   <= L_DSTART;
                end
                L_DSTART:
                begin
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    if (rpm_done)
                    begin
                        raw_rpm_reg <= desm_pkg::sat_quot(neg_reg, rpm_quo);
                        raw_spd_reg <= desm_pkg::sat_quot(neg_reg, spd_quo);
                        state_reg   <= L_EMA_MUL;
                    end
                end
                L_EMA_MUL:
                begin
                    prod_rpm_reg <= desm_pkg::PROD_W'(d_rpm) * desm_pkg::PROD_W'(gain_s);
                    prod_spd_reg <= desm_pkg::PROD_W'(d_spd) * desm_pkg::PROD_W'(gain_s);
                    state_reg    <= L_EMA_ADD;
                end
                L_EMA_ADD:
                begin
                    if (first_reg)
                    begin
                        filt_rpm_reg <= raw_rpm_reg;
                        filt_spd_reg <= raw_spd_reg;
                    end
                    else
                    begin
                        // arithmetic shift gives floor of the Q15 product
                        filt_rpm_reg <= desm_pkg::sat_ema(
                            desm_pkg::EMA_SUM_W'(filt_rpm_reg)
                            + desm_pkg::EMA_SUM_W'(prod_rpm_reg >>> desm_pkg::Q_SHIFT));
                        filt_spd_reg <= desm_pkg::sat_ema(
                            desm_pkg::EMA_SUM_W'(filt_spd_reg)
                            + desm_pkg::EMA_SUM_W'(prod_spd_reg >>> desm_pkg::Q_SHIFT));
                    end
                    state_reg <= L_DONE;
                end
                L_DONE:
                begin
                    if (cmd.release_res)
                    begin
                        state_reg <= L_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        sts.done     = (state_reg == L_DONE);
        sts.raw_rpm  = raw_rpm_reg;
        sts.raw_spd  = raw_spd_reg;
        sts.filt_rpm = filt_rpm_reg;
        sts.filt_spd = filt_spd_reg;
    end

    `DESM_ASSERT_IMP(a_div_sync, rpm_done, spd_done)
    `DESM_ASSERT_NXT(a_first_load, state_reg == L_EMA_ADD && first_reg, filt_rpm_reg == raw_rpm_reg && filt_spd_reg == raw_spd_reg)

endmodule

>>> rtl/core/dual_encoder_speed_meter_ema_top.sv
// ----------------------------------------------------------------------------
// dual_encoder_speed_meter_ema_top
// Two quadrature counters, per-window speed in two lanes, Q15 EMA, one
// result item per window end.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid/s_tready    s_tdata[7:0]   encoder sample item
//   m_*       out   m_tvalid/m_tready    m_tdata[319:0] window result item
//   cfg_*     in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item without a window end leaves the block idle. A window-end item holds
// the lanes until the 58-step restoring dividers and the EMA update finish.
// The result register holds one finished result; sample items are still taken
// while it waits. rst_n clears counts, sums and filters and resets config.
// ----------------------------------------------------------------------------
`include "dual_encoder_speed_meter_ema_top_macros.svh"

module dual_encoder_speed_meter_ema_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // clear_counts, edge_one, phase_b_one, edge_two, phase_b_two, tick, 2'b0
    input  logic [7:0]                        s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // raw_rpm_one, raw_rpm_two, raw_speed_one, raw_speed_two, filt_rpm_one,
    // filt_rpm_two, filt_speed_one, filt_speed_two, count_one, count_two
    output logic [10*desm_pkg::CNT_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [desm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [desm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

    state_t                              state_reg;
    logic [desm_pkg::WIN_W-1:0]          window_ticks_reg;
    logic [desm_pkg::GAIN_W-1:0]         gain_reg;
    logic [desm_pkg::CIRC_W-1:0]         circ_reg;
    logic [desm_pkg::CNT_W-1:0]          pulse_count_reg [desm_pkg::NUM_LANES];
    logic [desm_pkg::CNT_W-1:0]          last_count_reg  [desm_pkg::NUM_LANES];
    logic [desm_pkg::CNT_W-1:0]          window_sum_reg  [desm_pkg::NUM_LANES];
    logic [desm_pkg::WIN_W-1:0]          tick_counter_reg;
    logic                                first_reg;
    logic                                m_tvalid_reg;
    logic [10*desm_pkg::CNT_W-1:0]       m_tdata_reg;

    logic                                clear_counts;
    logic                                tick;
    logic [desm_pkg::NUM_LANES-1:0]      edge_in;
    logic [desm_pkg::NUM_LANES-1:0]      up_in;
    logic [desm_pkg::CNT_W-1:0]          pulse_count_next [desm_pkg::NUM_LANES];
    logic [desm_pkg::CNT_W-1:0]          window_sum_next  [desm_pkg::NUM_LANES];
    logic [desm_pkg::WIN_W-1:0]          tick_counter_next;
    logic                                accept;
    logic                                win_end;
    logic                                load;
    desm_pkg::lane_cmd_t                 lane_cmd [desm_pkg::NUM_LANES];
    desm_pkg::lane_sts_t                 lane_sts [desm_pkg::NUM_LANES];

    always_comb
    begin
        clear_counts = s_tdata[0];
        edge_in[0]   = s_tdata[1];
        up_in[0]     = s_tdata[2];
        edge_in[1]   = s_tdata[3];
        up_in[1]     = ~s_tdata[4];   // motor two counts the other way
        tick         = s_tdata[5];
        accept       = s_tvalid && s_tready;
        for (int i = 0; i < desm_pkg::NUM_LANES; i++)
        begin
            if (edge_in[i])
            begin
                pulse_count_next[i] = up_in[i] ? pulse_count_reg[i] + 1'b1
                                               : pulse_count_reg[i] - 1'b1;
            end
            else
            begin
                pulse_count_next[i] = pulse_count_reg[i];
            end
            window_sum_next[i] = window_sum_reg[i]
                               + (pulse_count_next[i] - last_count_reg[i]);
        end
        tick_counter_next = tick_counter_reg + 1'b1;
        win_end = tick && (tick_counter_next >= window_ticks_reg);
        load    = (state_reg == S_BUSY) && lane_sts[0].done && lane_sts[1].done
               && (!m_tvalid_reg || m_tready);
        for (int i = 0; i < desm_pkg::NUM_LANES; i++)
        begin
            lane_cmd[i].start       = accept && !clear_counts && win_end;
            lane_cmd[i].release_res = load;
            lane_cmd[i].clear       = accept && clear_counts;
            lane_cmd[i].first       = first_reg;
            lane_cmd[i].sum         = signed'(window_sum_next[i]);
            lane_cmd[i].win         = window_ticks_reg;
            lane_cmd[i].gain        = gain_reg;
            lane_cmd[i].circ        = circ_reg;
        end
    end

    for (genvar g = 0; g < desm_pkg::NUM_LANES; g++)
    begin : g_lane
        desm_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (lane_cmd[g]),
            .sts   (lane_sts[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg <= desm_pkg::WINDOW_RST;
            gain_reg         <= desm_pkg::GAIN_RST;
            circ_reg         <= desm_pkg::CIRC_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (desm_pkg::cfg_index_t'(cfg_index))
                desm_pkg::CFG_WINDOW_TICKS: window_ticks_reg <= cfg_data[desm_pkg::WIN_W-1:0];
                desm_pkg::CFG_EMA_GAIN:     gain_reg         <= cfg_data[desm_pkg::GAIN_W-1:0];
                desm_pkg::CFG_WHEEL_CIRC:   circ_reg         <= cfg_data[desm_pkg::CIRC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tick_counter_reg <= '0;
            first_reg        <= 1'b1;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            for (int i = 0; i < desm_pkg::NUM_LANES; i++)
            begin
                pulse_count_reg[i] <= '0;
                last_count_reg[i]  <= '0;
                window_sum_reg[i]  <= '0;
            end
        end
        else
        begin
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {pulse_count_reg[1], pulse_count_reg[0],
                                 lane_sts[1].filt_spd, lane_sts[0].filt_spd,
                                 lane_sts[1].filt_rpm, lane_sts[0].filt_rpm,
                                 lane_sts[1].raw_spd, lane_sts[0].raw_spd,
                                 lane_sts[1].raw_rpm, lane_sts[0].raw_rpm};
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (clear_counts)
                        begin
                            tick_counter_reg <= '0;
                            first_reg        <= 1'b1;
                            for (int i = 0; i < desm_pkg::NUM_LANES; i++)
                            begin
                                pulse_count_reg[i] <= '0;
                                last_count_reg[i]  <= '0;
                                window_sum_reg[i]  <= '0;
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < desm_pkg::NUM_LANES; i++)
                            begin
                                pulse_count_reg[i] <= pulse_count_next[i];
                                if (tick)
                                begin
                                    last_count_reg[i] <= pulse_count_next[i];
                                    window_sum_reg[i] <= win_end ? '0 : window_sum_next[i];
                                end
                            end
                            if (tick)
                            begin
                                tick_counter_reg <= win_end ? '0 : tick_counter_next;
                            end
                            if (win_end)
                            begin
                                first_reg <= 1'b0;
                                state_reg <= S_BUSY;
                            end
                        end
                    end
                end
                S_BUSY:
                begin
                    if (load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    `DESM_ASSERT_IMP(a_lane_sync, lane_sts[0].done, lane_sts[1].done)
    `DESM_ASSERT_NXT(a_count_frozen, state_reg == S_BUSY, $stable(pulse_count_reg[0]) && $stable(pulse_count_reg[1]))
    `DESM_ASSERT_IMP(a_sum_cleared, state_reg == S_BUSY, window_sum_reg[0] == '0 && window_sum_reg[1] == '0)

endmodule
